// ===== sv/idll_pkg.sv =====
// ----------------------------------------------------------------------------
// idll_pkg
// shared constants, codes and control types of the linked list engine
// ----------------------------------------------------------------------------
package idll_pkg;

   // default configuration
   localparam int SLOTS_DEFAULT      = 256;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // fixed field widths
   localparam int CMD_W    = 2;
   localparam int INDEX_W  = 8;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int LINK_W   = 8;
   localparam int COUNT_W  = 8;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic capture;   // latch request, launch table reads
      logic look;      // decode, first write pass
      logic link;      // second write pass of an insert
      logic push;      // load the response register
   } idll_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic ins_ok;    // insert will take a second write pass
      logic out_free;  // response register can take a new result
   } idll_sts_type;

endpackage

// ===== sv/indexed_doubly_linked_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list_engine_top
// slot table holding a circular doubly linked list with a free list
//
//   channel   direction  ports                     transfer when
//   request   in         req_cmd/index/value       req_valid && req_ready
//   response  out        rsp_status .. rsp_read_*  rsp_valid && rsp_ready
//
// a command steps the engine through capture, lookup and response, and a
// successful insert adds a link step, the second write pass on the single
// write port of the link tables; the response register is loaded in the
// response step, which follows the link step for a successful insert.
// one command is in flight at a time; a finished response waits in the
// output register while the next request is taken and worked on.
// reset needs no clearing pass: fresh slots are handed out in ascending
// order, so the fresh-slot mark qualifies the used bits.
// a stalled response only holds the engine at its final step.
// ----------------------------------------------------------------------------
module indexed_doubly_linked_list_engine_top #(
   parameter int SLOTS      = idll_pkg::SLOTS_DEFAULT,
   parameter int DATA_WIDTH = idll_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [idll_pkg::CMD_W-1:0]          req_cmd,
   input  logic [idll_pkg::INDEX_W-1:0]        req_index,
   input  logic signed [idll_pkg::VALUE_W-1:0] req_value,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [idll_pkg::STATUS_W-1:0]       rsp_status,
   output logic [idll_pkg::LINK_W-1:0]         rsp_slot,
   output logic [idll_pkg::LINK_W-1:0]         rsp_head_slot,
   output logic [idll_pkg::LINK_W-1:0]         rsp_tail_slot,
   output logic [idll_pkg::COUNT_W-1:0]        rsp_element_count,
   output logic signed [idll_pkg::VALUE_W-1:0] rsp_read_data,
   output logic [idll_pkg::LINK_W-1:0]         rsp_read_next,
   output logic [idll_pkg::LINK_W-1:0]         rsp_read_prev
);
   import idll_pkg::*;

   // command and status between sequencer and datapath
   idll_cmd_type cmd;
   idll_sts_type sts;

   // sequencer: accepts a request only when idle
   idll_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts_in    (sts),
      .cmd_out   (cmd)
   );

   // tables, head/tail/free-list registers and the response register
   idll_dp #(
      .SLOTS      (SLOTS),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd_in            (cmd),
      .sts_out           (sts),
      .req_cmd           (req_cmd),
      .req_index         (req_index),
      .req_value         (req_value),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_slot          (rsp_slot),
      .rsp_head_slot     (rsp_head_slot),
      .rsp_tail_slot     (rsp_tail_slot),
      .rsp_element_count (rsp_element_count),
      .rsp_read_data     (rsp_read_data),
      .rsp_read_next     (rsp_read_next),
      .rsp_read_prev     (rsp_read_prev)
   );

endmodule

// ===== sv/idll_ctrl.sv =====
// ----------------------------------------------------------------------------
// idll_ctrl
// command sequencer: capture, lookup, link, response
// ----------------------------------------------------------------------------
module idll_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  idll_pkg::idll_sts_type sts_in,
   output idll_pkg::idll_cmd_type cmd_out
);
   import idll_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOOK = 2'd1;
   localparam logic [1:0] S_LINK = 2'd2;
   localparam logic [1:0] S_PUSH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in        = state_ff;
      cmd_out         = '0;
      req_ready       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_out.capture = 1'b1;
               state_in        = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd_out.look = 1'b1;
            state_in     = sts_in.ins_ok ? S_LINK : S_PUSH;
         end
         S_LINK: begin
            cmd_out.link = 1'b1;
            state_in     = S_PUSH;
         end
         S_PUSH: begin
            if (sts_in.out_free) begin
               cmd_out.push = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/idll_dp.sv =====
// ----------------------------------------------------------------------------
// idll_dp
// slot tables, list registers and response register
// ----------------------------------------------------------------------------
module idll_dp #(
   parameter int SLOTS      = idll_pkg::SLOTS_DEFAULT,
   parameter int DATA_WIDTH = idll_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  idll_pkg::idll_cmd_type              cmd_in,
   output idll_pkg::idll_sts_type              sts_out,
   input  logic [idll_pkg::CMD_W-1:0]          req_cmd,
   input  logic [idll_pkg::INDEX_W-1:0]        req_index,
   input  logic signed [idll_pkg::VALUE_W-1:0] req_value,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [idll_pkg::STATUS_W-1:0]       rsp_status,
   output logic [idll_pkg::LINK_W-1:0]         rsp_slot,
   output logic [idll_pkg::LINK_W-1:0]         rsp_head_slot,
   output logic [idll_pkg::LINK_W-1:0]         rsp_tail_slot,
   output logic [idll_pkg::COUNT_W-1:0]        rsp_element_count,
   output logic signed [idll_pkg::VALUE_W-1:0] rsp_read_data,
   output logic [idll_pkg::LINK_W-1:0]         rsp_read_next,
   output logic [idll_pkg::LINK_W-1:0]         rsp_read_prev
);
   import idll_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam logic [IW:0] FRESH_END = (IW+1)'(SLOTS);

   // slot tables
   logic signed [DATA_WIDTH-1:0] data_mem [SLOTS];
   logic [IW-1:0]                next_mem [SLOTS];
   logic [IW-1:0]                prev_mem [SLOTS];
   logic                         used_mem [SLOTS];
   logic [IW-1:0]                link_mem [SLOTS];

   // registered table reads
   logic signed [DATA_WIDTH-1:0] data_rd_ff;
   logic [IW-1:0]                next_rd_ff;
   logic [IW-1:0]                prev_rd_ff;
   logic                         used_rd_ff;
   logic [IW-1:0]                link_rd_ff;

   // latched request
   logic [CMD_W-1:0]          cmd_ff;
   logic [INDEX_W-1:0]        idx_ff;
   logic signed [VALUE_W-1:0] val_ff;

   // list state
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [IW-1:0] free_head_ff, free_head_in;
   logic [IW:0]   fresh_ff, fresh_in;
   logic [IW-1:0] count_ff, count_in;

   // insert carry-over to the link pass
   logic [IW-1:0] new_ff, new_in;
   logic [IW-1:0] after_ff, after_in;

   // pending result
   logic [STATUS_W-1:0]       res_status_ff, res_status_in;
   logic [LINK_W-1:0]         res_slot_ff, res_slot_in;
   logic signed [VALUE_W-1:0] res_data_ff, res_data_in;
   logic [LINK_W-1:0]         res_next_ff, res_next_in;
   logic [LINK_W-1:0]         res_prev_ff, res_prev_in;

   // response register
   logic                      rsp_valid_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic [LINK_W-1:0]         rsp_slot_ff;
   logic [LINK_W-1:0]         rsp_head_ff;
   logic [LINK_W-1:0]         rsp_tail_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic signed [VALUE_W-1:0] rsp_data_ff;
   logic [LINK_W-1:0]         rsp_next_ff;
   logic [LINK_W-1:0]         rsp_prev_ff;

   // decode
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] idx_a;
   logic          in_table;
   logic          is_sent;
   logic          used_ok;
   logic          target_ok;
   logic [IW-1:0] cur_next;
   logic [IW-1:0] cur_prev;
   logic          have_free;
   logic          have_fresh;
   logic [IW-1:0] new_slot;
   logic          ins_ok;
   logic          del_ok;
   logic          rd_ok;

   // table write ports
   logic                         data_we;
   logic [IW-1:0]                data_wa;
   logic                         next_we;
   logic [IW-1:0]                next_wa;
   logic [IW-1:0]                next_wd;
   logic                         prev_we;
   logic [IW-1:0]                prev_wa;
   logic [IW-1:0]                prev_wd;
   logic                         used_we;
   logic [IW-1:0]                used_wa;
   logic                         used_wd;
   logic                         link_we;

   assign rd_addr = IW'(req_index);
   assign idx_a   = IW'(idx_ff);

   always_comb begin
      in_table   = 32'(idx_ff) < SLOTS;
      is_sent    = (idx_ff == '0);
      // slots at or above the fresh mark were never handed out
      used_ok    = !is_sent && ({1'b0, idx_a} < fresh_ff) && used_rd_ff;
      target_ok  = in_table && (is_sent || used_ok);
      cur_next   = is_sent ? head_ff : next_rd_ff;
      cur_prev   = is_sent ? tail_ff : prev_rd_ff;
      have_free  = (free_head_ff != '0);
      have_fresh = (fresh_ff != FRESH_END);
      new_slot   = have_free ? free_head_ff : IW'(fresh_ff);
      ins_ok     = (cmd_ff == CMD_INSERT) && target_ok && (have_free || have_fresh);
      del_ok     = (cmd_ff == CMD_DELETE) && in_table && used_ok;
      rd_ok      = (cmd_ff == CMD_READ) && target_ok;
   end

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_head_in  = free_head_ff;
      fresh_in      = fresh_ff;
      count_in      = count_ff;
      new_in        = new_ff;
      after_in      = after_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_data_in   = res_data_ff;
      res_next_in   = res_next_ff;
      res_prev_in   = res_prev_ff;
      data_we       = 1'b0;
      data_wa       = new_slot;
      next_we       = 1'b0;
      next_wa       = new_slot;
      next_wd       = cur_next;
      prev_we       = 1'b0;
      prev_wa       = new_slot;
      prev_wd       = idx_a;
      used_we       = 1'b0;
      used_wa       = new_slot;
      used_wd       = 1'b1;
      link_we       = 1'b0;

      if (cmd_in.look) begin
         res_status_in = STATUS_INVALID;
         res_slot_in   = '0;
         res_data_in   = '0;
         res_next_in   = '0;
         res_prev_in   = '0;
         if (ins_ok) begin
            // new slot record; neighbor links follow in the link pass
            data_we       = 1'b1;
            next_we       = 1'b1;
            prev_we       = 1'b1;
            used_we       = 1'b1;
            free_head_in  = have_free ? link_rd_ff : free_head_ff;
            fresh_in      = have_free ? fresh_ff : fresh_ff + 1'b1;
            count_in      = count_ff + 1'b1;
            new_in        = new_slot;
            after_in      = cur_next;
            res_status_in = STATUS_OK;
            res_slot_in   = LINK_W'(new_slot);
         end else if ((cmd_ff == CMD_INSERT) && target_ok) begin
            res_status_in = STATUS_FULL;
         end else if (del_ok) begin
            // unlink and push on the free list
            if (cur_prev == '0) begin
               head_in = cur_next;
            end else begin
               next_we = 1'b1;
               next_wa = cur_prev;
               next_wd = cur_next;
            end
            if (cur_next == '0) begin
               tail_in = cur_prev;
            end else begin
               prev_we = 1'b1;
               prev_wa = cur_next;
               prev_wd = cur_prev;
            end
            used_we       = 1'b1;
            used_wa       = idx_a;
            used_wd       = 1'b0;
            link_we       = 1'b1;
            free_head_in  = idx_a;
            count_in      = count_ff - 1'b1;
            res_status_in = STATUS_OK;
            res_slot_in   = idx_ff;
         end else if (rd_ok) begin
            res_status_in = STATUS_OK;
            res_slot_in   = idx_ff;
            res_data_in   = is_sent ? '0 : VALUE_W'(data_rd_ff);
            res_next_in   = LINK_W'(cur_next);
            res_prev_in   = LINK_W'(cur_prev);
         end
      end

      if (cmd_in.link) begin
         if (idx_a == '0) begin
            head_in = new_ff;
         end else begin
            next_we = 1'b1;
            next_wa = idx_a;
            next_wd = new_ff;
         end
         if (after_ff == '0) begin
            tail_in = new_ff;
         end else begin
            prev_we = 1'b1;
            prev_wa = after_ff;
            prev_wd = new_ff;
         end
      end
   end

   // tables: one write and one registered read per table
   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[data_wa] <= DATA_WIDTH'(val_ff);
      end
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      if (used_we) begin
         used_mem[used_wa] <= used_wd;
      end
      if (link_we) begin
         link_mem[idx_a] <= free_head_ff;
      end
      if (cmd_in.capture) begin
         data_rd_ff <= data_mem[rd_addr];
         next_rd_ff <= next_mem[rd_addr];
         prev_rd_ff <= prev_mem[rd_addr];
         used_rd_ff <= used_mem[rd_addr];
         link_rd_ff <= link_mem[free_head_ff];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd_in.capture) begin
         cmd_ff <= req_cmd;
         idx_ff <= req_index;
         val_ff <= req_value;
      end
      new_ff        <= new_in;
      after_ff      <= after_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_data_ff   <= res_data_in;
      res_next_ff   <= res_next_in;
      res_prev_ff   <= res_prev_in;
      if (cmd_in.push) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_head_ff   <= LINK_W'(head_ff);
         rsp_tail_ff   <= LINK_W'(tail_ff);
         rsp_count_ff  <= COUNT_W'(count_ff);
         rsp_data_ff   <= res_data_ff;
         rsp_next_ff   <= res_next_ff;
         rsp_prev_ff   <= res_prev_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         free_head_ff <= '0;
         fresh_ff     <= (IW+1)'(1);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_head_ff <= free_head_in;
         fresh_ff     <= fresh_in;
         count_ff     <= count_in;
         if (cmd_in.push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts_out.ins_ok   = ins_ok;
   assign sts_out.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_head_slot     = rsp_head_ff;
   assign rsp_tail_slot     = rsp_tail_ff;
   assign rsp_element_count = rsp_count_ff;
   assign rsp_read_data     = rsp_data_ff;
   assign rsp_read_next     = rsp_next_ff;
   assign rsp_read_prev     = rsp_prev_ff;

endmodule

// ===== tb/sv/tb_indexed_doubly_linked_list_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_doubly_linked_list_engine_top
// self-checking bench for the slot table linked list engine: a tracker keeps
// its own copy of the table, links and free list, works out the response of
// every request transfer and compares it field by field with what comes out
// ----------------------------------------------------------------------------
module tb_indexed_doubly_linked_list_engine_top;
   import idll_pkg::*;

   // table size seen by the tracker, same as the block's default
   localparam int SLOT_COUNT = SLOTS_DEFAULT;

   // the one command code the block does not know
   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

   // random run shape
   localparam int RANDOM_ITEMS  = 1800;
   localparam int PHASE_ITEMS   = 600;
   localparam int LONG_HOLD     = 400;
   localparam int DRAIN_CYCLES  = 20;
   localparam int CYCLE_LIMIT   = 500000;

   // stimulus episodes: grow the list, shrink it, or churn around
   localparam int EPISODE_GROW  = 0;
   localparam int EPISODE_SHRINK = 1;
   localparam int EPISODE_MIXED = 2;

   // one response, packed the way the ports come out
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [LINK_W-1:0]   slot;
      logic [LINK_W-1:0]   head_slot;
      logic [LINK_W-1:0]   tail_slot;
      logic [COUNT_W-1:0]  element_count;
      logic [VALUE_W-1:0]  read_data;
      logic [LINK_W-1:0]   read_next;
      logic [LINK_W-1:0]   read_prev;
   } list_reply_type;

   // ------------------------------------------------------------------------
   // list tracker: shadow of the slot table plus the queue of replies due
   // ------------------------------------------------------------------------
   class list_tracker_type;
      logic [VALUE_W-1:0] slot_value [SLOT_COUNT];
      logic [LINK_W-1:0]  next_link [SLOT_COUNT];
      logic [LINK_W-1:0]  prev_link [SLOT_COUNT];
      bit                 in_use [SLOT_COUNT];
      logic [LINK_W-1:0]  recycled_head;
      logic [8:0]         fresh_mark;
      logic [COUNT_W-1:0] live;
      list_reply_type     replies_due [$];
      int                 failures;

      function new();
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_value[i] = '0;
            next_link[i]  = '0;
            prev_link[i]  = '0;
            in_use[i]     = 1'b0;
         end
         recycled_head = '0;
         fresh_mark    = 9'd1;
         live          = '0;
         failures      = 0;
      endfunction

      // apply one accepted request and queue the reply it must produce
      function void note_command(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx,
                                 logic [VALUE_W-1:0] value);
         list_reply_type r;
         logic [LINK_W-1:0] n;
         logic [LINK_W-1:0] after;
         logic [LINK_W-1:0] p;
         logic [LINK_W-1:0] q;
         r = '0;
         r.status = STATUS_INVALID;
         if (cmd == CMD_INSERT && (idx == 0 || in_use[idx])) begin
            n = '0;
            // recycled slots go out before fresh ones
            if (recycled_head != 0) begin
               n = recycled_head;
               recycled_head = next_link[n];
            end else if (fresh_mark < SLOT_COUNT) begin
               n = fresh_mark[LINK_W-1:0];
               fresh_mark = fresh_mark + 9'd1;
            end
            if (n == 0) begin
               r.status = STATUS_FULL;
            end else begin
               after = next_link[idx];
               slot_value[n] = value;
               prev_link[n] = idx;
               next_link[n] = after;
               next_link[idx] = n;
               prev_link[after] = n;
               in_use[n] = 1'b1;
               live = live + 1'b1;
               r.status = STATUS_OK;
               r.slot = n;
            end
         end else if (cmd == CMD_DELETE && idx != 0 && in_use[idx]) begin
            p = prev_link[idx];
            q = next_link[idx];
            next_link[p] = q;
            prev_link[q] = p;
            in_use[idx] = 1'b0;
            next_link[idx] = recycled_head;
            prev_link[idx] = '0;
            recycled_head = idx;
            live = live - 1'b1;
            r.status = STATUS_OK;
            r.slot = idx;
         end else if (cmd == CMD_READ && (idx == 0 || in_use[idx])) begin
            r.status = STATUS_OK;
            r.slot = idx;
            r.read_data = (idx == 0) ? '0 : slot_value[idx];
            r.read_next = next_link[idx];
            r.read_prev = prev_link[idx];
         end
         r.head_slot = next_link[0];
         r.tail_slot = prev_link[0];
         r.element_count = live;
         replies_due.push_back(r);
      endfunction

      function void compare_field(string name, logic [VALUE_W-1:0] want,
                                  logic [VALUE_W-1:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_reply(list_reply_type got);
         list_reply_type want;
         if (replies_due.size() == 0) begin
            $error("response transfer with no request outstanding");
            failures++;
            return;
         end
         want = replies_due.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("slot", want.slot, got.slot);
         compare_field("head_slot", want.head_slot, got.head_slot);
         compare_field("tail_slot", want.tail_slot, got.tail_slot);
         compare_field("element_count", want.element_count, got.element_count);
         compare_field("read_data", want.read_data, got.read_data);
         compare_field("read_next", want.read_next, got.read_next);
         compare_field("read_prev", want.read_prev, got.read_prev);
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // signals; every input of the block starts at a known value
   // ------------------------------------------------------------------------
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [CMD_W-1:0]           req_cmd = CMD_INSERT;
   logic [INDEX_W-1:0]         req_index = '0;
   logic signed [VALUE_W-1:0]  req_value = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic [LINK_W-1:0]          rsp_slot;
   logic [LINK_W-1:0]          rsp_head_slot;
   logic [LINK_W-1:0]          rsp_tail_slot;
   logic [COUNT_W-1:0]         rsp_element_count;
   logic signed [VALUE_W-1:0]  rsp_read_data;
   logic [LINK_W-1:0]          rsp_read_next;
   logic [LINK_W-1:0]          rsp_read_prev;

   // idle rates in percent, changed by the stimulus between phases
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   // one-shot request for a long response stall
   bit hold_go = 1'b0;

   list_tracker_type tracker = new();

   indexed_doubly_linked_list_engine_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_index         (req_index),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_slot          (rsp_slot),
      .rsp_head_slot     (rsp_head_slot),
      .rsp_tail_slot     (rsp_tail_slot),
      .rsp_element_count (rsp_element_count),
      .rsp_read_data     (rsp_read_data),
      .rsp_read_next     (rsp_read_next),
      .rsp_read_prev     (rsp_read_prev)
   );

   // 12 ns clock
   initial begin
      forever #6 clock = ~clock;
   end

   // watchdog: a stuck handshake ends the run here
   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // response side: random back-pressure, plus one long stall so the engine
   // backs up all the way to its request port
   // ------------------------------------------------------------------------
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   // every response transfer is checked against the oldest reply due
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_reply('{rsp_status, rsp_slot, rsp_head_slot, rsp_tail_slot,
                               rsp_element_count, rsp_read_data, rsp_read_next,
                               rsp_read_prev});
      end
   end

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   // offer one request, maybe after a random gap, and return once it has
   // been transferred; the tracker is updated at that same edge
   task automatic send_command(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx,
                               logic [VALUE_W-1:0] value);
      if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_index <= idx;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      tracker.note_command(cmd, idx, value);
   endtask

   // some slot currently on the list, or the sentinel when the list is empty
   function automatic logic [INDEX_W-1:0] pick_live_slot();
      int start;
      int s;
      start = $urandom_range(1, SLOT_COUNT - 1);
      for (int k = 0; k < SLOT_COUNT - 1; k++) begin
         s = 1 + (start - 1 + k) % (SLOT_COUNT - 1);
         if (tracker.in_use[s]) return s[INDEX_W-1:0];
      end
      return '0;
   endfunction

   // mostly well-formed commands aimed at live slots, with some noise:
   // any code including the unknown one, any index, free or never used
   task automatic draw_command(int mode, output logic [CMD_W-1:0] cmd,
                               output logic [INDEX_W-1:0] idx,
                               output logic [VALUE_W-1:0] value);
      int r;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 7) == 0) begin
         value = '0;
         case ($urandom_range(0, 3))
            0: value = 32'h0000_0000;
            1: value = 32'hffff_ffff;
            2: value = 32'h7fff_ffff;
            default: value = 32'h8000_0000;
         endcase
      end else begin
         value = $urandom;
      end
      if ($urandom_range(0, 99) < 8) begin
         cmd = CMD_W'($urandom_range(0, 3));
         idx = INDEX_W'($urandom_range(0, 255));
      end else begin
         if (mode == EPISODE_GROW)
            cmd = (r < 90) ? CMD_INSERT : (r < 95) ? CMD_DELETE : CMD_READ;
         else if (mode == EPISODE_SHRINK)
            cmd = (r < 15) ? CMD_INSERT : (r < 80) ? CMD_DELETE : CMD_READ;
         else
            cmd = (r < 40) ? CMD_INSERT : (r < 75) ? CMD_DELETE : CMD_READ;
         if (cmd == CMD_INSERT && $urandom_range(0, 3) == 0)
            idx = '0;
         else if (cmd == CMD_READ && $urandom_range(0, 9) == 0)
            idx = '0;
         else
            idx = pick_live_slot();
      end
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      logic [CMD_W-1:0]   cmd;
      logic [INDEX_W-1:0] idx;
      logic [VALUE_W-1:0] value;
      int mode;
      int episode;
      int episode_left;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty list corner cases first
      send_command(CMD_READ, 8'd0, 32'd0);            // sentinel of an empty list
      send_command(CMD_DELETE, 8'd0, 32'd0);          // sentinel cannot go
      send_command(CMD_READ, 8'd5, 32'd0);            // never used slot
      send_command(CMD_DELETE, 8'd7, 32'd0);          // free slot
      send_command(CMD_INSERT, 8'd9, 32'd1);          // target is free
      send_command(CMD_UNKNOWN, 8'd0, 32'd0);
      // build a four element list, hitting head, tail and middle placement
      send_command(CMD_INSERT, 8'd0, 32'h7fff_ffff);  // first element
      send_command(CMD_INSERT, 8'd1, 32'h8000_0000);  // after the tail
      send_command(CMD_INSERT, 8'd0, 32'h0000_0000);  // new head
      send_command(CMD_INSERT, 8'd3, 32'hffff_ffff);  // in the middle
      send_command(CMD_READ, 8'd1, 32'd0);
      send_command(CMD_READ, 8'd2, 32'd0);
      send_command(CMD_READ, 8'd3, 32'd0);
      send_command(CMD_READ, 8'd4, 32'd0);
      send_command(CMD_READ, 8'd0, 32'd0);
      // unlink head and tail, then poke the freed slots
      send_command(CMD_DELETE, 8'd3, 32'd0);
      send_command(CMD_DELETE, 8'd2, 32'd0);
      send_command(CMD_READ, 8'd3, 32'd0);
      send_command(CMD_INSERT, 8'd3, 32'd7);
      send_command(CMD_DELETE, 8'd3, 32'd0);
      // free list reuse, last freed first
      send_command(CMD_INSERT, 8'd4, 32'h5555_aaaa);
      send_command(CMD_INSERT, 8'd0, 32'haaaa_5555);
      // top index and the unknown code with every bit set
      send_command(CMD_READ, 8'd255, 32'd0);
      send_command(CMD_INSERT, 8'd255, 32'h1234_5678);
      send_command(CMD_UNKNOWN, 8'd255, 32'hffff_ffff);

      // random: episodes that fill the table to full, drain it and churn;
      // the first one is long enough to run the table out of slots
      episode = 0;
      episode_left = 0;
      mode = EPISODE_GROW;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 0) begin
            tx_idle_pct = 10;
            rx_idle_pct = 48;
         end else if (i == PHASE_ITEMS) begin
            tx_idle_pct = 48;
            rx_idle_pct = 10;
            hold_go = 1'b1;
         end else if (i == 2 * PHASE_ITEMS) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         if (episode_left == 0) begin
            mode = episode % 3;
            if (episode == 0)
               episode_left = 400;
            else if (mode == EPISODE_GROW)
               episode_left = $urandom_range(200, 330);
            else
               episode_left = $urandom_range(100, 250);
            episode++;
         end
         draw_command(mode, cmd, idx, value);
         send_command(cmd, idx, value);
         episode_left--;
      end
      req_valid <= 1'b0;

      // let the last responses out, then a short settle
      while (tracker.replies_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/idll_pkg.sv
sv/idll_ctrl.sv
sv/idll_dp.sv
sv/indexed_doubly_linked_list_engine_top.sv
tb/sv/tb_indexed_doubly_linked_list_engine_top.sv
